>>> hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/gcb_pkg.sv
`default_nettype none

package gcb_pkg;

    localparam int CHROMOSOME_COUNT = 24;
    localparam int KNOWN_LENGTHS    = 24;

    localparam int CHR_W     = 5;
    localparam int POS_W     = 28;
    localparam int BS_W      = 28;
    localparam int BIN_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = POS_W / DIV_STEPS;

    localparam logic [BS_W-1:0] BIN_SIZE_RESET = BS_W'(1000000);

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED = CFG_IDX_W'(1);

    localparam logic [POS_W-1:0] CHR_LENGTH [1:KNOWN_LENGTHS] = '{
        28'd249250621, 28'd243199373, 28'd198022430, 28'd191154276,
        28'd180915260, 28'd171115067, 28'd159138663, 28'd146364022,
        28'd141213431, 28'd135534747, 28'd135006516, 28'd133851895,
        28'd115169878, 28'd107349540, 28'd102531392, 28'd90354753,
        28'd81195210,  28'd78077248,  28'd59128983,  28'd63025520,
        28'd48129895,  28'd51304566,  28'd155270560, 28'd59373566
    };

    // Per-word sideband carried down the divider.
    typedef struct packed {
        logic             bld;
        logic [CHR_W-1:0] chr;
        logic             kept;
        logic [BIN_W-1:0] first;
        logic [BIN_W-1:0] last;
    } t_tag;

    typedef struct packed {
        logic             vld;
        logic [CHR_W-1:0] chr;
    } t_issue;

    typedef struct packed {
        logic             vld;
        logic [CHR_W-1:0] chr;
        logic [POS_W-1:0] span;
    } t_exit;

    typedef struct packed {
        logic             kept;
        logic [BIN_W-1:0] first;
        logic [BIN_W-1:0] last;
    } t_look;

    function automatic logic chr_known(input logic [CHR_W-1:0] c);
        return (c != '0) && (32'(c) <= CHROMOSOME_COUNT) && (32'(c) <= KNOWN_LENGTHS);
    endfunction

    function automatic logic [POS_W-1:0] chr_length(input logic [CHR_W-1:0] c);
        return chr_known(c) ? CHR_LENGTH[c] : '0;
    endfunction

    function automatic logic chr_kept(input logic [CHR_W-1:0] c,
                                      input logic [CHR_W-1:0] sel);
        return chr_known(c) && ((sel == '0) || (sel == c));
    endfunction

endpackage

`default_nettype wire

>>> hdl/gcb_div_stage.sv
`default_nettype none

module gcb_div_stage import gcb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_valid,
    input  wire t_tag             i_tag,
    input  wire logic [POS_W-1:0] i_rem,
    input  wire logic [POS_W-1:0] i_dq,
    input  wire logic [BS_W-1:0]  i_divisor,
    output      logic             o_valid,
    output      t_tag             o_tag,
    output      logic [POS_W-1:0] o_rem,
    output      logic [POS_W-1:0] o_dq
);

    logic             r_valid;
    t_tag             r_tag;
    logic [POS_W-1:0] r_rem;
    logic [POS_W-1:0] r_dq;
    logic [POS_W-1:0] n_rem;
    logic [POS_W-1:0] n_dq;

    // dq holds the remaining dividend bits, quotient bits shift in from the bottom
    always_comb begin
        logic [POS_W:0] trial;
        n_rem = i_rem;
        n_dq  = i_dq;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {n_rem, n_dq[POS_W-1]};
            n_dq  = {n_dq[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                trial   = trial - {1'b0, i_divisor};
                n_dq[0] = 1'b1;
            end
            n_rem = trial[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tag <= i_tag;
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;

endmodule

`default_nettype wire

>>> hdl/gcb_table.sv
`default_nettype none

module gcb_table import gcb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CHR_W-1:0] i_sel,
    input  wire logic             i_issue_take,
    input  wire t_exit            i_exit,
    input  wire logic [CHR_W-1:0] i_look_chr,
    output      logic             o_building,
    output      t_issue           o_issue,
    output      logic [POS_W-1:0] o_issue_len,
    output      t_look            o_look,
    output      logic [BIN_W-1:0] o_total
);

    logic             r_building;
    logic             r_issuing;
    logic [CHR_W-1:0] r_issue_chr;
    logic [BIN_W-1:0] r_next;
    logic [BIN_W-1:0] r_total;
    logic [BIN_W-1:0] r_first [1:CHROMOSOME_COUNT];
    logic [BIN_W-1:0] r_last  [1:CHROMOSOME_COUNT];

    logic             exit_kept;
    logic [BIN_W-1:0] n_last;
    logic [BIN_W-1:0] n_next;
    logic             look_kept;

    assign exit_kept = chr_kept(i_exit.chr, i_sel);
    assign n_last    = exit_kept ? r_next + BIN_W'(i_exit.span) : r_next;
    assign n_next    = exit_kept ? n_last + BIN_W'(1) : r_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_building  <= 1'b1;
            r_issuing   <= 1'b1;
            r_issue_chr <= CHR_W'(1);
            r_next      <= '0;
        end else begin
            if (i_issue_take) begin
                r_issue_chr <= r_issue_chr + CHR_W'(1);
                if (r_issue_chr == CHR_W'(CHROMOSOME_COUNT)) begin
                    r_issuing <= 1'b0;
                end
            end
            if (i_exit.vld) begin
                r_next <= n_next;
                if (i_exit.chr == CHR_W'(CHROMOSOME_COUNT)) begin
                    r_building <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exit.vld) begin
            r_first[i_exit.chr] <= r_next;
            r_last[i_exit.chr]  <= n_last;
            if (i_exit.chr == CHR_W'(CHROMOSOME_COUNT)) begin
                r_total <= n_next;
            end
        end
    end

    assign look_kept    = chr_kept(i_look_chr, i_sel);
    assign o_look.kept  = look_kept;
    assign o_look.first = look_kept ? r_first[i_look_chr] : '0;
    assign o_look.last  = look_kept ? r_last[i_look_chr] : '0;

    assign o_building  = r_building;
    assign o_issue.vld = r_issuing;
    assign o_issue.chr = r_issue_chr;
    assign o_issue_len = chr_length(r_issue_chr);
    assign o_total     = r_total;

endmodule

`default_nettype wire

>>> hdl/genome_coordinate_binner.sv
`default_nettype none

// Channel  Handshake                   Payload
// in       i_in_valid / o_in_ready     i_chromosome, i_position
// out      o_out_valid / i_out_ready   o_bin_index, o_bin_valid, o_total_bins
// cfg      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One word per cycle while the output does not stall and no table build runs:
// 7 divider stages of 4 quotient bits each, then the output register that adds
// the first bin and checks the range. After reset and after each write to the
// bin size or selection register the bin tables are rebuilt by sending the 24
// lengths through the same divider; o_in_ready and o_cfg_ready are low meanwhile.
// Stalls on the output back up stage by stage; empty stages still fill.

module genome_coordinate_binner import gcb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire logic [CHR_W-1:0]     i_chromosome,
    input  wire logic [POS_W-1:0]     i_position,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    output      logic [BIN_W-1:0]     o_bin_index,
    output      logic                 o_bin_valid,
    output      logic [BIN_W-1:0]     o_total_bins,
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BS_W-1:0]      i_cfg_data
);

    localparam int LAST = DIV_STAGES - 1;

    logic [BS_W-1:0]  r_divisor;
    logic [CHR_W-1:0] r_sel;
    logic             r_out_valid;
    logic [BIN_W-1:0] r_bin_index;
    logic             r_bin_valid;

    logic             cfg_write;
    logic             start;
    logic             building;
    t_issue           issue;
    logic [POS_W-1:0] issue_len;
    t_look            look;
    t_exit            exit_w;
    logic [BIN_W-1:0] total;

    logic             out_free;
    logic [LAST:0]    sv;
    logic [LAST:0]    free;
    logic [LAST:0]    sink;
    t_tag             stag [DIV_STAGES];
    logic [POS_W-1:0] srem [DIV_STAGES];
    logic [POS_W-1:0] sdq  [DIV_STAGES];

    logic             e_valid;
    t_tag             e_tag;
    logic [POS_W-1:0] e_dq;

    logic [BIN_W:0]   sum;
    logic             in_range;

    // configuration
    assign o_cfg_ready = !building;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign start       = cfg_write &&
                         (i_cfg_index == CFG_BIN_SIZE || i_cfg_index == CFG_SELECTED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= BIN_SIZE_RESET;
            r_sel     <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_BIN_SIZE: r_divisor <= (i_cfg_data == '0) ? BS_W'(1) : i_cfg_data;
                CFG_SELECTED: r_sel     <= i_cfg_data[CHR_W-1:0];
                default:      ;
            endcase
        end
    end

    gcb_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_sel        (r_sel),
        .i_issue_take (free[0] && issue.vld),
        .i_exit       (exit_w),
        .i_look_chr   (i_chromosome),
        .o_building   (building),
        .o_issue      (issue),
        .o_issue_len  (issue_len),
        .o_look       (look),
        .o_total      (total)
    );

    // stage 0 entry: table build words take priority while building
    assign o_in_ready = free[0] && !building;

    always_comb begin
        e_tag = '0;
        if (issue.vld) begin
            e_valid   = 1'b1;
            e_tag.bld = 1'b1;
            e_tag.chr = issue.chr;
            e_dq      = issue_len;
        end else begin
            e_valid    = i_in_valid && !building;
            e_tag.chr  = i_chromosome;
            e_tag.kept = look.kept;
            e_tag.first = look.first;
            e_tag.last = look.last;
            e_dq       = i_position;
        end
    end

    // stall chain
    assign out_free = !r_out_valid || i_out_ready;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        if (g == LAST) begin : g_sink_out
            assign sink[g] = stag[g].bld || out_free;
        end else begin : g_sink_next
            assign sink[g] = free[g + 1];
        end
        assign free[g] = !sv[g] || sink[g];

        if (g == 0) begin : g_first
            gcb_div_stage u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_load    (free[g]),
                .i_valid   (e_valid),
                .i_tag     (e_tag),
                .i_rem     ('0),
                .i_dq      (e_dq),
                .i_divisor (r_divisor),
                .o_valid   (sv[g]),
                .o_tag     (stag[g]),
                .o_rem     (srem[g]),
                .o_dq      (sdq[g])
            );
        end else begin : g_rest
            gcb_div_stage u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_load    (free[g]),
                .i_valid   (sv[g - 1]),
                .i_tag     (stag[g - 1]),
                .i_rem     (srem[g - 1]),
                .i_dq      (sdq[g - 1]),
                .i_divisor (r_divisor),
                .o_valid   (sv[g]),
                .o_tag     (stag[g]),
                .o_rem     (srem[g]),
                .o_dq      (sdq[g])
            );
        end
    end

    // last remainder is not needed
    assign exit_w.vld  = sv[LAST] && stag[LAST].bld;
    assign exit_w.chr  = stag[LAST].chr;
    assign exit_w.span = sdq[LAST];

    // output stage
    assign sum      = {1'b0, stag[LAST].first} + (BIN_W + 1)'(sdq[LAST]);
    assign in_range = stag[LAST].kept && (sum <= {1'b0, stag[LAST].last});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= sv[LAST] && !stag[LAST].bld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && sv[LAST] && !stag[LAST].bld) begin
            r_bin_index <= in_range ? sum[BIN_W-1:0] : '0;
            r_bin_valid <= in_range;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_index  = r_bin_index;
    assign o_bin_valid  = r_bin_valid;
    assign o_total_bins = total;

endmodule

`default_nettype wire

>>> hdl/gcb_checker.sv
`default_nettype none

`include "assert_macros.svh"

module gcb_checker import gcb_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [BIN_W-1:0]     o_bin_index,
    input wire logic                 o_bin_valid,
    input wire logic [BIN_W-1:0]     o_total_bins,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index
);

    logic out_stall;
    logic cfg_known;
    logic in_acc;

    assign out_stall = o_out_valid && !i_out_ready;
    assign cfg_known = i_cfg_valid && o_cfg_ready &&
                       (i_cfg_index == CFG_BIN_SIZE || i_cfg_index == CFG_SELECTED);
    assign in_acc    = i_in_valid && o_in_ready;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_out_valid && $stable(o_bin_index) && $stable(o_bin_valid))
    `ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_bin_valid,
        o_bin_index == '0)
    `ASSERT_SAME(a_index_below_total, i_clk, i_rst_n, o_out_valid && o_bin_valid,
        o_bin_index < o_total_bins)
    `ASSERT_SAME(a_build_blocks_input, i_clk, i_rst_n, in_acc, o_cfg_ready)
    `ASSERT_NEXT(a_write_rebuilds, i_clk, i_rst_n, cfg_known,
        !o_in_ready && !o_cfg_ready)

endmodule

bind genome_coordinate_binner gcb_checker u_gcb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_bin_index  (o_bin_index),
    .o_bin_valid  (o_bin_valid),
    .o_total_bins (o_total_bins),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_index  (i_cfg_index)
);

`default_nettype wire

>>> bench/tb_genome_coordinate_binner.sv
module tb_genome_coordinate_binner;
    timeunit 1ns;
    timeprecision 1ps;

    import gcb_pkg::*;

    localparam int N_FIXED        = 6;
    localparam int N_PHASES       = 13;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = CFG_IDX_W'(3);

    localparam logic [POS_W-1:0] MAX_POS     = '1;
    localparam logic [BIN_W-1:0] RESET_TOTAL = BIN_W'(3113);

    typedef struct packed {
        logic [BIN_W-1:0] idx;
        logic             ok;
        logic [BIN_W-1:0] total;
    } bin_result_t;

    typedef struct packed {
        logic        pinned;
        bin_result_t res;
    } pin_t;

    typedef struct packed {
        logic [CHR_W-1:0] chr;
        logic [POS_W-1:0] pos;
        pin_t             pin;
    } dir_row_t;

    // Default registers: bin size 1000000, all chromosomes kept.
    localparam int N_DIRECTED = 17;
    localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
        '{5'd0,  28'd0,         '{1'b1, '{32'd0,    1'b0, RESET_TOTAL}}},
        '{5'd0,  28'hFFFFFFF,   '{1'b1, '{32'd0,    1'b0, RESET_TOTAL}}},
        '{5'd1,  28'd0,         '{1'b1, '{32'd0,    1'b1, RESET_TOTAL}}},
        '{5'd1,  28'd249250621, '{1'b1, '{32'd249,  1'b1, RESET_TOTAL}}},
        '{5'd1,  28'd249999999, '{1'b0, '{32'd0,    1'b0, 32'd0}}},
        '{5'd1,  28'd250000000, '{1'b1, '{32'd0,    1'b0, RESET_TOTAL}}},
        '{5'd24, 28'd59373566,  '{1'b1, '{32'd3112, 1'b1, RESET_TOTAL}}},
        '{5'd24, 28'hFFFFFFF,   '{1'b1, '{32'd0,    1'b0, RESET_TOTAL}}},
        '{5'd25, 28'd1000,      '{1'b1, '{32'd0,    1'b0, RESET_TOTAL}}},
        '{5'd31, 28'hFFFFFFF,   '{1'b1, '{32'd0,    1'b0, RESET_TOTAL}}},
        '{5'd2,  28'd1000000,   '{1'b0, '{32'd0,    1'b0, 32'd0}}},
        '{5'd16, 28'd5555555,   '{1'b0, '{32'd0,    1'b0, 32'd0}}},
        '{5'd23, 28'd155270560, '{1'b0, '{32'd0,    1'b0, 32'd0}}},
        '{5'd15, 28'h5555555,   '{1'b0, '{32'd0,    1'b0, 32'd0}}},
        '{5'd10, 28'hAAAAAAA,   '{1'b0, '{32'd0,    1'b0, 32'd0}}},
        '{5'd22, 28'd999999,    '{1'b0, '{32'd0,    1'b0, 32'd0}}},
        '{5'd12, 28'd134000000, '{1'b0, '{32'd0,    1'b0, 32'd0}}}
    };

    // zero size, max size, single chromosome, selection out of range, ...
    localparam logic [BS_W-1:0] FIXED_BIN_SIZE [0:N_FIXED-1] = '{
        28'd0, 28'hFFFFFFF, 28'd1, 28'd1000000, 28'd97, 28'd1000000
    };
    localparam logic [BS_W-1:0] FIXED_SELECT [0:N_FIXED-1] = '{
        28'd0, 28'd0, 28'd24, 28'hFFFFFFF, 28'h5555559, 28'd1
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CHR_W-1:0]     i_chromosome;
    logic [POS_W-1:0]     i_position;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BIN_W-1:0]     o_bin_index;
    logic                 o_bin_valid;
    logic [BIN_W-1:0]     o_total_bins;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BS_W-1:0]      i_cfg_data;

    genome_coordinate_binner u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_chromosome (i_chromosome),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_bin_index  (o_bin_index),
        .o_bin_valid  (o_bin_valid),
        .o_total_bins (o_total_bins),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Bin layout mirror
    logic [BS_W-1:0]  bin_size_q;
    logic [CHR_W-1:0] sel_q;
    logic [BIN_W-1:0] first_bin [0:CHROMOSOME_COUNT];
    logic [BIN_W-1:0] bins_total;

    bin_result_t bin_q [$];
    pin_t        drv_pin;
    int          pressure;
    int          n_fail;
    int unsigned idle_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint unsigned kept_len(input logic [CHR_W-1:0] c);
        if (c == '0 || c > CHROMOSOME_COUNT || c > KNOWN_LENGTHS) return 0;
        if (sel_q != '0 && sel_q != c) return 0;
        return CHR_LENGTH[c];
    endfunction

    function automatic void rebuild_bins();
        longint unsigned bs, nxt, len;
        bs  = (bin_size_q == '0) ? 1 : bin_size_q;
        nxt = 0;
        first_bin[0] = '0;
        for (int c = 1; c <= CHROMOSOME_COUNT; c++) begin
            len = kept_len(CHR_W'(c));
            first_bin[c] = BIN_W'(nxt);
            if (len != 0) nxt = nxt + len / bs + 1;
        end
        bins_total = BIN_W'(nxt);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [BS_W-1:0] data);
        case (idx)
            CFG_BIN_SIZE: bin_size_q = data;
            CFG_SELECTED: sel_q = data[CHR_W-1:0];
            default: return;
        endcase
        rebuild_bins();
    endfunction

    function automatic bin_result_t locate_bin(input logic [CHR_W-1:0] c,
                                               input logic [POS_W-1:0] p);
        longint unsigned bs, len, off;
        bin_result_t r;
        bs      = (bin_size_q == '0) ? 1 : bin_size_q;
        len     = kept_len(c);
        r.idx   = '0;
        r.ok    = 1'b0;
        r.total = bins_total;
        if (len != 0) begin
            off = p / bs;
            if (off <= len / bs) begin
                r.idx = BIN_W'(first_bin[c] + off);
                r.ok  = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (pressure == 0) return 0;
        if (r < ((pressure == 1) ? 65 : 35)) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(input string what, input logic [BIN_W-1:0] want,
                                 input logic [BIN_W-1:0] got);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic idle_in(input int unsigned n);
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_coord(input logic [CHR_W-1:0] c, input logic [POS_W-1:0] p,
                              input pin_t pin);
        i_in_valid   <= 1'b1;
        i_chromosome <= c;
        i_position   <= p;
        drv_pin      <= pin;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (bin_q.size() != 0);
    endtask

    // accepted words and register writes feed the mirror
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bin_size_q = BIN_SIZE_RESET;
            sel_q      = '0;
            rebuild_bins();
        end else begin
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                if (drv_pin.pinned) bin_q.push_back(drv_pin.res);
                else bin_q.push_back(locate_bin(i_chromosome, i_position));
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        bin_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (bin_q.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("%0t: word with nothing expected, bin_index %0d bin_valid %0d",
                             $time, o_bin_index, o_bin_valid);
            end else begin
                want = bin_q.pop_front();
                if (o_bin_index !== want.idx) flag_mismatch("bin_index", want.idx, o_bin_index);
                if (o_bin_valid !== want.ok)
                    flag_mismatch("bin_valid", BIN_W'(want.ok), BIN_W'(o_bin_valid));
                if (o_total_bins !== want.total)
                    flag_mismatch("total_bins", want.total, o_total_bins);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("** genome_coordinate_binner: FAILED **");
            $finish;
        end
    end

    // output backpressure
    initial begin
        int unsigned hold;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                hold = gap_len();
                i_out_ready <= (hold == 0);
            end
        end
    end

    initial begin
        int unsigned      n_items, r;
        logic [CHR_W-1:0] c;
        logic [POS_W-1:0] p;
        logic [BS_W-1:0]  bs_pick;
        longint unsigned  len, bs, past;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_chromosome = '0;
        i_position   = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        drv_pin      = '0;
        pressure     = 1;
        n_fail       = 0;
        idle_cycles  = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            idle_in(gap_len());
            send_coord(DIRECTED[k].chr, DIRECTED[k].pos, DIRECTED[k].pin);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            pressure = ph % 3;

            if (ph < N_FIXED) begin
                write_reg(CFG_BIN_SIZE, FIXED_BIN_SIZE[ph]);
                write_reg(CFG_SELECTED, FIXED_SELECT[ph]);
                if (ph == 3) write_reg(CFG_UNMAPPED_2, '1);
                if (ph == 5) write_reg(CFG_UNMAPPED_3, '0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    write_reg(($urandom_range(0, 1) != 0) ? CFG_UNMAPPED_2 : CFG_UNMAPPED_3,
                              BS_W'($urandom));
                if (r < 75 || r >= 90) begin
                    case ($urandom_range(0, 9))
                        0:       bs_pick = '0;
                        1:       bs_pick = BS_W'(1);
                        2:       bs_pick = '1;
                        3:       bs_pick = BS_W'($urandom_range(2, 64));
                        4, 5:    bs_pick = BS_W'($urandom_range(100, 100000));
                        6, 7:    bs_pick = BS_W'($urandom_range(100000, 5000000));
                        8:       bs_pick = BS_W'($urandom_range(5000000, 268435455));
                        default: bs_pick = BIN_SIZE_RESET;
                    endcase
                    write_reg(CFG_BIN_SIZE, bs_pick);
                end
                if (r >= 40) begin
                    r = $urandom_range(0, 99);
                    if (r < 40) c = '0;
                    else if (r < 85) c = CHR_W'($urandom_range(1, CHROMOSOME_COUNT));
                    else c = CHR_W'($urandom_range(CHROMOSOME_COUNT + 1, (1 << CHR_W) - 1));
                    write_reg(CFG_SELECTED, (BS_W'($urandom) & ~BS_W'((1 << CHR_W) - 1)) |
                                            BS_W'(c));
                end
            end
            i_cfg_valid <= 1'b0;

            n_items = $urandom_range(120, 170);
            repeat (n_items) begin
                r = $urandom_range(0, 99);
                if (r < 4) c = '0;
                else if (r < 8)
                    c = CHR_W'($urandom_range(CHROMOSOME_COUNT + 1, (1 << CHR_W) - 1));
                else if (sel_q != '0 && sel_q <= CHROMOSOME_COUNT && r < 55) c = sel_q;
                else c = CHR_W'($urandom_range(1, CHROMOSOME_COUNT));
                len = (c != '0 && c <= KNOWN_LENGTHS) ? CHR_LENGTH[c] : 0;
                bs  = (bin_size_q == '0) ? 1 : bin_size_q;

                r = $urandom_range(0, 99);
                if (len != 0 && r < 70) begin
                    p = POS_W'($urandom_range(0, 32'(len)));
                end else if (len != 0 && r < 84) begin
                    // around the end of the last bin, or the chromosome length
                    past = (r < 77) ? (len / bs + 1) * bs : len;
                    past = past + $urandom_range(0, 2) - 1;
                    p    = (past > MAX_POS) ? MAX_POS : POS_W'(past);
                end else if (r < 94) begin
                    p = POS_W'($urandom);
                end else begin
                    p = ($urandom_range(0, 1) != 0) ? MAX_POS : '0;
                end

                idle_in(gap_len());
                send_coord(c, p, '0);
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("** genome_coordinate_binner: PASSED **");
        end else begin
            $display("** genome_coordinate_binner: FAILED **");
        end
        $finish;
    end

endmodule
